[hdl/pcbd_pkg.sv]
// Package: shared constants and codes for the prefix code bit decoder.
`timescale 1ns / 1ps
package pcbd_pkg;

  // Default geometry of the decoder.
  localparam int TABLE_ENTRIES_DEF = 16;
  localparam int MAX_CODE_BITS_DEF = 14;
  localparam int SYMBOL_BITS_DEF   = 16;

  // Derived default field widths.
  localparam int IDX_W_DEF = $clog2(TABLE_ENTRIES_DEF);
  localparam int LEN_W_DEF = $clog2(MAX_CODE_BITS_DEF + 1);

  // Symbol counter and its limit register.
  localparam int              COUNT_W     = 16;
  localparam logic [COUNT_W-1:0] LIMIT_RESET = '1;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_ENTRIES_IN_USE = 1'd0;
  localparam cfg_idx_t CFG_SYMBOL_LIMIT   = 1'd1;

  // Input transaction modes.
  typedef logic [1:0] mode_t;
  localparam mode_t MODE_LOAD    = 2'd0;
  localparam mode_t MODE_DECODE  = 2'd1;
  localparam mode_t MODE_RESTART = 2'd2;

endpackage

[hdl/pcbd_ifs.sv]
// Interfaces: input and result channels of the prefix code bit decoder.
`timescale 1ns / 1ps
interface pcbd_in_if #(
  parameter int IDX_W  = pcbd_pkg::IDX_W_DEF,
  parameter int CODE_W = pcbd_pkg::MAX_CODE_BITS_DEF,
  parameter int LEN_W  = pcbd_pkg::LEN_W_DEF,
  parameter int SYM_W  = pcbd_pkg::SYMBOL_BITS_DEF
);
  logic                valid;
  logic                ready;
  pcbd_pkg::mode_t     mode;
  logic [IDX_W-1:0]    entry_index;
  logic [CODE_W-1:0]   entry_code;
  logic [LEN_W-1:0]    entry_length;
  logic [SYM_W-1:0]    entry_symbol;
  logic                code_bit;

  modport source (output valid, mode, entry_index, entry_code, entry_length,
                  entry_symbol, code_bit, input ready);
  modport sink   (input valid, mode, entry_index, entry_code, entry_length,
                  entry_symbol, code_bit, output ready);
endinterface

interface pcbd_out_if #(
  parameter int SYM_W = pcbd_pkg::SYMBOL_BITS_DEF
);
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol;
  logic             code_error;
  logic             last_symbol;

  modport source (output valid, symbol, code_error, last_symbol, input ready);
  modport sink   (input valid, symbol, code_error, last_symbol, output ready);
endinterface

[hdl/pcbd_table.sv]
// Code table: entry storage and parallel match against the running code.
`timescale 1ns / 1ps
module pcbd_table #(
  parameter int TABLE_ENTRIES = pcbd_pkg::TABLE_ENTRIES_DEF,
  parameter int MAX_CODE_BITS = pcbd_pkg::MAX_CODE_BITS_DEF,
  parameter int SYMBOL_BITS   = pcbd_pkg::SYMBOL_BITS_DEF,
  parameter int IDX_W         = $clog2(TABLE_ENTRIES),
  parameter int LEN_W         = $clog2(MAX_CODE_BITS + 1),
  parameter int EIU_W         = $clog2(TABLE_ENTRIES + 1)
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [IDX_W-1:0]         wr_idx,
  input  logic [MAX_CODE_BITS-1:0] wr_code,
  input  logic [LEN_W-1:0]         wr_len,
  input  logic [SYMBOL_BITS-1:0]   wr_sym,
  input  logic [EIU_W-1:0]         entries_in_use,
  input  logic [MAX_CODE_BITS-1:0] probe_code,
  input  logic [LEN_W-1:0]         probe_len,
  output logic                     hit,
  output logic [SYMBOL_BITS-1:0]   hit_symbol
);

  logic [MAX_CODE_BITS-1:0] code_r [TABLE_ENTRIES];
  logic [LEN_W-1:0]         len_r  [TABLE_ENTRIES];
  logic [SYMBOL_BITS-1:0]   sym_r  [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] match;

  // Slots past the table depth (non power-of-two depth) are dropped.
  always_ff @(posedge clk) begin
    if (wr_en && ({1'b0, wr_idx} < (IDX_W + 1)'(TABLE_ENTRIES))) begin
      code_r[wr_idx] <= wr_code;
      len_r[wr_idx]  <= wr_len;
      sym_r[wr_idx]  <= wr_sym;
    end
  end

  // Per-slot compare; only the low len bits of the stored code count.
  always_comb begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      match[i] = (EIU_W'(i) < entries_in_use) &&
                 (len_r[i] != '0) &&
                 (len_r[i] <= LEN_W'(MAX_CODE_BITS)) &&
                 (len_r[i] == probe_len) &&
                 ((code_r[i] & ~({MAX_CODE_BITS{1'b1}} << len_r[i])) == probe_code);
    end
  end

  // Highest matching index wins.
  always_comb begin
    hit        = 1'b0;
    hit_symbol = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (match[i]) begin
        hit        = 1'b1;
        hit_symbol = sym_r[i];
      end
    end
  end

endmodule

[hdl/prefix_code_bit_decoder.sv]
// Top level: bit-serial prefix code decoder with a loadable code table.
//
// Decodes a prefix-coded stream one bit per input transaction and takes
// one transaction every clock cycle while the result side is not stalled.
// Each transaction sits in the input register, where the running-code
// update and the parallel compare against all table entries happen, and
// then lands in the result register. Mode 0 loads
// a table slot (entry_index, entry_code, entry_length, entry_symbol), mode
// 1 shifts code_bit into the running code, mode 2 restarts the stream;
// only decode transactions can give a result. A match emits the slot's
// symbol (highest slot wins on duplicates); a running code that reaches
// MAX_CODE_BITS without a match gives a result with code_error set and
// symbol zero. The result that brings the count to symbol_limit carries
// last_symbol, after which decode bits are dropped until a restart. Table
// slots have no reset: load every slot below entries_in_use before
// decoding. Configure only while the block is idle.
`timescale 1ns / 1ps
module prefix_code_bit_decoder #(
  parameter int TABLE_ENTRIES = pcbd_pkg::TABLE_ENTRIES_DEF,
  parameter int MAX_CODE_BITS = pcbd_pkg::MAX_CODE_BITS_DEF,
  parameter int SYMBOL_BITS   = pcbd_pkg::SYMBOL_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  pcbd_in_if.sink                       in_ch,
  pcbd_out_if.source                    out_ch,
  input  logic                          cfg_we,
  input  pcbd_pkg::cfg_idx_t            cfg_idx,
  input  logic [pcbd_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int LEN_W = $clog2(MAX_CODE_BITS + 1);
  localparam int EIU_W = $clog2(TABLE_ENTRIES + 1);

  // Configuration registers
  logic [EIU_W-1:0]             entries_in_use_r;
  logic [pcbd_pkg::COUNT_W-1:0] symbol_limit_r;

  // Input register stage
  logic                     in_valid_r;
  pcbd_pkg::mode_t          in_mode_r;
  logic [IDX_W-1:0]         in_idx_r;
  logic [MAX_CODE_BITS-1:0] in_code_r;
  logic [LEN_W-1:0]         in_len_r;
  logic [SYMBOL_BITS-1:0]   in_sym_r;
  logic                     in_bit_r;

  // Decoder state
  logic [MAX_CODE_BITS-1:0]     running_code_r, running_code_nxt;
  logic [LEN_W-1:0]             running_length_r, running_length_nxt;
  logic [pcbd_pkg::COUNT_W-1:0] decoded_count_r, decoded_count_nxt;
  logic                         stream_done_r, stream_done_nxt;

  // Result register
  logic                   out_valid_r, out_valid_nxt;
  logic [SYMBOL_BITS-1:0] out_symbol_r, out_symbol_nxt;
  logic                   out_code_error_r, out_code_error_nxt;
  logic                   out_last_symbol_r, out_last_symbol_nxt;

  logic                     advance;
  logic [MAX_CODE_BITS-1:0] probe_code;
  logic [LEN_W-1:0]         probe_len;
  logic                     hit;
  logic [SYMBOL_BITS-1:0]   hit_symbol;
  logic [pcbd_pkg::COUNT_W-1:0] count_inc;

  // The staged transaction moves on whenever the result slot is free or
  // being drained this cycle, so a full pipe still takes one per cycle.
  assign advance     = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || advance;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.symbol      = out_symbol_r;
  assign out_ch.code_error  = out_code_error_r;
  assign out_ch.last_symbol = out_last_symbol_r;

  // Running code with the new bit shifted in (upper bits stay zero).
  assign probe_code = {running_code_r[MAX_CODE_BITS-2:0], in_bit_r};
  assign probe_len  = running_length_r + LEN_W'(1);
  assign count_inc  = decoded_count_r + pcbd_pkg::COUNT_W'(1);

  pcbd_table #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .MAX_CODE_BITS (MAX_CODE_BITS),
    .SYMBOL_BITS   (SYMBOL_BITS),
    .IDX_W         (IDX_W),
    .LEN_W         (LEN_W),
    .EIU_W         (EIU_W)
  ) u_table (
    .clk            (clk),
    .wr_en          (advance && (in_mode_r == pcbd_pkg::MODE_LOAD)),
    .wr_idx         (in_idx_r),
    .wr_code        (in_code_r),
    .wr_len         (in_len_r),
    .wr_sym         (in_sym_r),
    .entries_in_use (entries_in_use_r),
    .probe_code     (probe_code),
    .probe_len      (probe_len),
    .hit            (hit),
    .hit_symbol     (hit_symbol)
  );

  // Next state and result for the staged transaction.
  always_comb begin
    running_code_nxt    = running_code_r;
    running_length_nxt  = running_length_r;
    decoded_count_nxt   = decoded_count_r;
    stream_done_nxt     = stream_done_r;
    out_valid_nxt       = 1'b0;
    out_symbol_nxt      = '0;
    out_code_error_nxt  = 1'b0;
    out_last_symbol_nxt = 1'b0;
    case (in_mode_r)
      pcbd_pkg::MODE_RESTART: begin
        running_code_nxt   = '0;
        running_length_nxt = '0;
        decoded_count_nxt  = '0;
        stream_done_nxt    = 1'b0;
      end
      pcbd_pkg::MODE_DECODE: begin
        if (!stream_done_r) begin
          if (hit) begin
            running_code_nxt    = '0;
            running_length_nxt  = '0;
            decoded_count_nxt   = count_inc;
            out_valid_nxt       = 1'b1;
            out_symbol_nxt      = hit_symbol;
            out_last_symbol_nxt = (count_inc == symbol_limit_r);
            stream_done_nxt     = (count_inc == symbol_limit_r);
          end else if (probe_len >= LEN_W'(MAX_CODE_BITS)) begin
            // unmatched full-length code: flag and flush
            running_code_nxt   = '0;
            running_length_nxt = '0;
            out_valid_nxt      = 1'b1;
            out_code_error_nxt = 1'b1;
          end else begin
            running_code_nxt   = probe_code;
            running_length_nxt = probe_len;
          end
        end
      end
      default: begin
        // loads touch only the table; mode 3 is a no-op
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_in_use_r <= '0;
      symbol_limit_r   <= pcbd_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        pcbd_pkg::CFG_ENTRIES_IN_USE: entries_in_use_r <= cfg_data[EIU_W-1:0];
        pcbd_pkg::CFG_SYMBOL_LIMIT:   symbol_limit_r   <= cfg_data[pcbd_pkg::COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Input stage: control reset, payload free-running on acceptance.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_mode_r <= in_ch.mode;
      in_idx_r  <= in_ch.entry_index;
      in_code_r <= in_ch.entry_code;
      in_len_r  <= in_ch.entry_length;
      in_sym_r  <= in_ch.entry_symbol;
      in_bit_r  <= in_ch.code_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_code_r   <= '0;
      running_length_r <= '0;
      decoded_count_r  <= '0;
      stream_done_r    <= 1'b0;
      out_valid_r      <= 1'b0;
    end else if (advance) begin
      running_code_r   <= running_code_nxt;
      running_length_r <= running_length_nxt;
      decoded_count_r  <= decoded_count_nxt;
      stream_done_r    <= stream_done_nxt;
      out_valid_r      <= out_valid_nxt;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_symbol_r      <= out_symbol_nxt;
      out_code_error_r  <= out_code_error_nxt;
      out_last_symbol_r <= out_last_symbol_nxt;
    end
  end

  // Running code is flushed before it can reach full length.
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    running_length_r < LEN_W'(MAX_CODE_BITS))
    else $error("running length reached maximum");

  // An empty running code carries no bits.
  a_empty_code: assert property (@(posedge clk) disable iff (!rst_n)
    (running_length_r == '0) |-> (running_code_r == '0))
    else $error("stale bits in empty running code");

  // Error results carry no symbol and no last flag.
  a_err_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_code_error_r) |-> (out_symbol_r == '0 && !out_last_symbol_r))
    else $error("malformed error result");

  // Stream completion comes only with a last-symbol result.
  a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(stream_done_r) |-> (out_valid_r && out_last_symbol_r))
    else $error("stream done without last symbol");

  // A staged transaction is not lost while the result side stalls.
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !advance) |=> in_valid_r)
    else $error("staged transaction dropped");

endmodule

[tb/sv/testbench.sv]
// Testbench: prefix code bit decoder checked against its own symbol predictor.
`timescale 1ns / 1ps
module testbench;

  localparam int CODE_W = pcbd_pkg::MAX_CODE_BITS_DEF;
  localparam int SYM_W  = pcbd_pkg::SYMBOL_BITS_DEF;
  localparam int IDX_W  = pcbd_pkg::IDX_W_DEF;
  localparam int LEN_W  = pcbd_pkg::LEN_W_DEF;
  localparam int SLOTS  = pcbd_pkg::TABLE_ENTRIES_DEF;
  localparam int CFG_W  = pcbd_pkg::CFG_DATA_W;
  localparam int CNT_W  = pcbd_pkg::COUNT_W;

  // The package names modes 0..2 only; 3 is the unused encoding.
  localparam pcbd_pkg::mode_t MODE_UNUSED = 2'd3;

  // A settling margin after the result queue empties covers loads and
  // restarts that leave nothing to wait for.
  localparam int SETTLE_CYCLES   = 4;
  // Far above any legal run of stalls, even at 58% per cycle.
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int ITEMS_PER_PHASE = 195;
  // Short stream at a limit of zero; the wrapped count is never reached.
  localparam int ZERO_LIMIT_SYMBOLS = 40;

  typedef struct packed {
    pcbd_pkg::mode_t   mode;
    logic [IDX_W-1:0]  idx;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
    logic [SYM_W-1:0]  sym;
    logic              code_bit;
  } bit_item_t;

  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic             err;
    logic             last;
  } sym_result_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t              kind;
    bit_item_t              it;
    bit                     use_typed;
    sym_result_t            typed_res;
    pcbd_pkg::cfg_idx_t     reg_idx;
    logic [CFG_W-1:0]       reg_val;
  } dir_row_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  pcbd_pkg::cfg_idx_t cfg_idx;
  logic [CFG_W-1:0]   cfg_data;

  pcbd_in_if  in_ch ();
  pcbd_out_if out_ch ();

  prefix_code_bit_decoder i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------
  // Predictor state: code table, running code, symbol count, config
  // ---------------------------------------------------------------
  logic [CODE_W-1:0]  tbl_code [SLOTS];
  logic [LEN_W-1:0]   tbl_len  [SLOTS];
  logic [SYM_W-1:0]   tbl_sym  [SLOTS];
  logic [CODE_W-1:0]  run_code;
  int                 run_len;
  logic [CNT_W-1:0]   sym_count;
  logic               stream_over;
  logic [4:0]         n_active;
  logic [CNT_W-1:0]   sym_limit;

  sym_result_t expected_symbols [$];

  int send_idle_pct;
  int recv_stall_pct;
  int n_items;
  int n_results;
  int n_code_errors;
  int n_last;
  int n_mismatch;
  int idle_cycles;

  // Applies one accepted transaction to the predictor; returns 1 when a
  // result is due and fills res.
  function automatic bit decode_predict(input bit_item_t it, output sym_result_t res);
    int               active;
    int               len;
    int               i;
    bit               hit;
    logic [SYM_W-1:0] hit_sym;
    res     = '0;
    hit     = 1'b0;
    hit_sym = '0;
    case (it.mode)
      pcbd_pkg::MODE_LOAD: begin
        tbl_code[it.idx] = it.code;
        tbl_len[it.idx]  = it.len;
        tbl_sym[it.idx]  = it.sym;
        return 1'b0;
      end
      pcbd_pkg::MODE_RESTART: begin
        run_code    = '0;
        run_len     = 0;
        sym_count   = '0;
        stream_over = 1'b0;
        return 1'b0;
      end
      pcbd_pkg::MODE_DECODE: ;
      default: return 1'b0;
    endcase
    // done stream swallows bits until a restart
    if (stream_over) return 1'b0;

    run_code = {run_code[CODE_W-2:0], it.code_bit};
    run_len++;
    active = (n_active > SLOTS) ? SLOTS : n_active;
    // scan upward so the highest matching slot is the one kept
    for (i = 0; i < active; i++) begin
      len = tbl_len[i];
      if (len != 0 && len <= CODE_W && len == run_len &&
          (tbl_code[i] & CODE_W'((1 << len) - 1)) == run_code) begin
        hit     = 1'b1;
        hit_sym = tbl_sym[i];
      end
    end

    if (hit) begin
      run_code  = '0;
      run_len   = 0;
      sym_count = sym_count + 1'b1;
      res.sym   = hit_sym;
      if (sym_count == sym_limit) begin
        res.last    = 1'b1;
        stream_over = 1'b1;
      end
      return 1'b1;
    end
    // full-length code with no match: flag and drop, count unchanged
    if (run_len >= CODE_W) begin
      run_code = '0;
      run_len  = 0;
      res.err  = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit_item_t random_fields();
    bit_item_t it;
    it.mode     = pcbd_pkg::mode_t'($urandom_range(0, 3));
    it.idx      = IDX_W'($urandom);
    it.code     = CODE_W'($urandom);
    it.len      = LEN_W'($urandom);
    it.sym      = SYM_W'($urandom);
    it.code_bit = 1'($urandom);
    return it;
  endfunction

  // Mostly short codes so matches come often; now and then a length
  // that can never match (zero or past the maximum).
  function automatic logic [LEN_W-1:0] pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return '0;
    if (r < 6) return LEN_W'(CODE_W + 1);
    if (r < 30) return LEN_W'($urandom_range(6, CODE_W));
    return LEN_W'($urandom_range(1, 5));
  endfunction

  function automatic dir_row_t item_row(input pcbd_pkg::mode_t m, input int idx,
                                        input int code, input int len, input int sym,
                                        input bit b);
    dir_row_t r;
    r.kind        = ROW_ITEM;
    r.it.mode     = m;
    r.it.idx      = IDX_W'(idx);
    r.it.code     = CODE_W'(code);
    r.it.len      = LEN_W'(len);
    r.it.sym      = SYM_W'(sym);
    r.it.code_bit = b;
    r.use_typed   = 1'b0;
    r.typed_res   = '0;
    r.reg_idx     = pcbd_pkg::CFG_ENTRIES_IN_USE;
    r.reg_val     = '0;
    return r;
  endfunction

  function automatic dir_row_t cfg_row(input pcbd_pkg::cfg_idx_t ri, input int val);
    dir_row_t r;
    r         = item_row(pcbd_pkg::MODE_LOAD, 0, 0, 0, 0, 1'b0);
    r.kind    = ROW_CFG;
    r.reg_idx = ri;
    r.reg_val = CFG_W'(val);
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch @%0t: %s", $time, msg);
    n_mismatch++;
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance
  // with valid still high, so a following transaction can go back to back.
  task automatic drive_item(input bit_item_t it, input bit use_typed,
                            input sym_result_t typed_res);
    sym_result_t res;
    bit          due;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.mode         <= it.mode;
    in_ch.entry_index  <= it.idx;
    in_ch.entry_code   <= it.code;
    in_ch.entry_length <= it.len;
    in_ch.entry_symbol <= it.sym;
    in_ch.code_bit     <= it.code_bit;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    due = decode_predict(it, res);
    if (use_typed) begin
      due = 1'b1;
      res = typed_res;
    end
    if (due) expected_symbols.push_back(res);
    if (it.mode != MODE_UNUSED) n_items++;
    @(negedge clk);
  endtask

  task automatic send_item(input bit_item_t it);
    drive_item(it, 1'b0, '0);
  endtask

  // Drop valid and let the pipeline run dry before touching registers.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_symbols.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // Called at a falling edge, returns at one; the extra wait after the
  // enable drops keeps it from being lowered and raised in the same step.
  task automatic write_reg(input pcbd_pkg::cfg_idx_t ri, input logic [CFG_W-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= ri;
    cfg_data <= val;
    if (ri == pcbd_pkg::CFG_ENTRIES_IN_USE) n_active = val[4:0];
    else sym_limit = val[CNT_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Restart, fresh table in all slots, then mostly whole codewords of the
  // table with noise, broken codes, reloads and restarts mixed in.
  task automatic run_random_phase(input int send_pct, input int recv_pct,
                                  input int entries, input int limit);
    bit_item_t         it;
    int                start;
    int                r;
    int                k;
    int                nb;
    int                slot;
    int                active;
    logic [CODE_W-1:0] word;
    settle();
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    write_reg(pcbd_pkg::CFG_ENTRIES_IN_USE, CFG_W'(entries));
    write_reg(pcbd_pkg::CFG_SYMBOL_LIMIT, CFG_W'(limit));
    start   = n_items;
    it      = random_fields();
    it.mode = pcbd_pkg::MODE_RESTART;
    send_item(it);
    for (k = 0; k < SLOTS; k++) begin
      it      = random_fields();
      it.mode = pcbd_pkg::MODE_LOAD;
      it.idx  = IDX_W'(k);
      it.len  = pick_len();
      send_item(it);
    end
    while (n_items - start < ITEMS_PER_PHASE) begin
      it = random_fields();
      r  = $urandom_range(0, 99);
      if ((stream_over && r < 50) || r < 3) begin
        it.mode = pcbd_pkg::MODE_RESTART;
        send_item(it);
      end else if (r < 6) begin
        it.mode = pcbd_pkg::MODE_LOAD;
        it.len  = pick_len();
        send_item(it);
      end else if (r < 8) begin
        it.mode = MODE_UNUSED;
        send_item(it);
      end else if (r < 22) begin
        it.mode = pcbd_pkg::MODE_DECODE;
        send_item(it);
      end else begin
        active = (n_active > SLOTS) ? SLOTS : n_active;
        slot   = $urandom_range(0, active - 1);
        nb     = tbl_len[slot];
        word   = tbl_code[slot];
        if (nb == 0 || nb > CODE_W) begin
          nb   = $urandom_range(1, CODE_W);
          word = CODE_W'($urandom);
        end
        for (k = nb - 1; k >= 0; k--) begin
          it          = random_fields();
          it.mode     = pcbd_pkg::MODE_DECODE;
          it.code_bit = word[k];
          send_item(it);
        end
      end
    end
  endtask

  // ---------------------------------------------------------------
  // Result side: random stalls, field-by-field compare
  // ---------------------------------------------------------------
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    sym_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_results++;
      if (out_ch.code_error) n_code_errors++;
      if (out_ch.last_symbol) n_last++;
      if (expected_symbols.size() == 0) begin
        report_mismatch($sformatf("unexpected result symbol=%h err=%b last=%b",
                                  out_ch.symbol, out_ch.code_error, out_ch.last_symbol));
      end else begin
        want = expected_symbols.pop_front();
        if (out_ch.symbol !== want.sym)
          report_mismatch($sformatf("symbol %h, want %h", out_ch.symbol, want.sym));
        if (out_ch.code_error !== want.err)
          report_mismatch($sformatf("code_error %b, want %b", out_ch.code_error, want.err));
        if (out_ch.last_symbol !== want.last)
          report_mismatch($sformatf("last_symbol %b, want %b", out_ch.last_symbol,
                                    want.last));
      end
    end
  end

  // Any cycle without a transaction on either channel counts toward a hang.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles, %0d results pending",
                 idle_cycles, expected_symbols.size());
        $display("status: fail");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------
  initial begin
    dir_row_t  dir_rows [$];
    dir_row_t  row;
    bit_item_t it;
    int        k;

    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_idx            = pcbd_pkg::CFG_ENTRIES_IN_USE;
    cfg_data           = '0;
    in_ch.valid        = 1'b0;
    in_ch.mode         = pcbd_pkg::MODE_LOAD;
    in_ch.entry_index  = '0;
    in_ch.entry_code   = '0;
    in_ch.entry_length = '0;
    in_ch.entry_symbol = '0;
    in_ch.code_bit     = 1'b0;
    send_idle_pct      = 0;
    recv_stall_pct     = 0;
    n_items            = 0;
    n_results          = 0;
    n_code_errors      = 0;
    n_last             = 0;
    n_mismatch         = 0;
    idle_cycles        = 0;

    // predictor at its reset values
    run_code    = '0;
    run_len     = 0;
    sym_count   = '0;
    stream_over = 1'b0;
    n_active    = '0;
    sym_limit   = pcbd_pkg::LIMIT_RESET;

    // Directed table.
    // Right after reset no slot takes part: fourteen ones can only end
    // in a code error (symbol zero, no last flag).
    for (k = 0; k < CODE_W; k++) begin
      row = item_row(pcbd_pkg::MODE_DECODE, 0, 0, 0, 0, 1'b1);
      if (k == CODE_W - 1) begin
        row.use_typed = 1'b1;
        row.typed_res = '{sym: '0, err: 1'b1, last: 1'b0};
      end
      dir_rows.push_back(row);
    end
    // unused mode, every field at its top
    dir_rows.push_back(item_row(MODE_UNUSED, 15, 16383, 15, 65535, 1'b1));
    // slot 0: code 0 of length 1, symbol 0
    dir_rows.push_back(item_row(pcbd_pkg::MODE_LOAD, 0, 0, 1, 0, 1'b0));
    // slot 1: all ones at full length, top symbol
    dir_rows.push_back(item_row(pcbd_pkg::MODE_LOAD, 1, 16383, 14, 65535, 1'b0));
    // slot 2: junk above the length; low bits read "10"
    dir_rows.push_back(item_row(pcbd_pkg::MODE_LOAD, 2, 16382, 2, 'h1234, 1'b0));
    // slot 3: same code as slot 2, higher slot should win
    dir_rows.push_back(item_row(pcbd_pkg::MODE_LOAD, 3, 2, 2, 'hBEEF, 1'b0));
    // slots 4 and 5: zero length and over-long, neither can match
    dir_rows.push_back(item_row(pcbd_pkg::MODE_LOAD, 4, 0, 0, 'h0005, 1'b0));
    dir_rows.push_back(item_row(pcbd_pkg::MODE_LOAD, 5, 1, 15, 'h0006, 1'b0));
    dir_rows.push_back(cfg_row(pcbd_pkg::CFG_ENTRIES_IN_USE, 6));
    dir_rows.push_back(cfg_row(pcbd_pkg::CFG_SYMBOL_LIMIT, 2));
    dir_rows.push_back(item_row(pcbd_pkg::MODE_DECODE, 0, 0, 0, 0, 1'b0));
    dir_rows.push_back(item_row(pcbd_pkg::MODE_DECODE, 0, 0, 0, 0, 1'b1));
    // "10": duplicate hit, second symbol of the stream closes it
    row = item_row(pcbd_pkg::MODE_DECODE, 0, 0, 0, 0, 1'b0);
    row.use_typed = 1'b1;
    row.typed_res = '{sym: 16'hBEEF, err: 1'b0, last: 1'b1};
    dir_rows.push_back(row);
    // stream done: this bit is dropped
    dir_rows.push_back(item_row(pcbd_pkg::MODE_DECODE, 0, 0, 0, 0, 1'b0));
    dir_rows.push_back(item_row(pcbd_pkg::MODE_RESTART, 0, 0, 0, 0, 1'b0));
    dir_rows.push_back(item_row(pcbd_pkg::MODE_DECODE, 0, 0, 0, 0, 1'b0));

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        settle();
        write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
      end else begin
        drive_item(dir_rows[i].it, dir_rows[i].use_typed, dir_rows[i].typed_res);
      end
    end

    // Random phases: full table at the default limit, too many entries
    // with one symbol per stream, a single entry, then a middle setting.
    run_random_phase(0, 0, SLOTS, 65535);
    run_random_phase(58, 0, 31, 1);
    run_random_phase(0, 58, 1, $urandom_range(3, 12));
    run_random_phase(24, 24, $urandom_range(2, 15), $urandom_range(4, 40));

    // Limit zero: the count would have to wrap before a last flag, so a
    // short stream of symbols must carry none.
    settle();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_reg(pcbd_pkg::CFG_ENTRIES_IN_USE, CFG_W'(1));
    write_reg(pcbd_pkg::CFG_SYMBOL_LIMIT, CFG_W'(0));
    it      = random_fields();
    it.mode = pcbd_pkg::MODE_RESTART;
    send_item(it);
    it         = random_fields();
    it.mode    = pcbd_pkg::MODE_LOAD;
    it.idx     = '0;
    it.len     = LEN_W'(1);
    it.code[0] = 1'b0;
    send_item(it);
    for (k = 0; k < ZERO_LIMIT_SYMBOLS; k++) begin
      it          = random_fields();
      it.mode     = pcbd_pkg::MODE_DECODE;
      it.code_bit = 1'b0;
      send_item(it);
    end

    settle();
    $display("run: %0d input transactions, %0d results", n_items, n_results);
    $display("run: %0d code errors, %0d stream ends, %0d mismatches",
             n_code_errors, n_last, n_mismatch);
    if (n_mismatch == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
